// ----- src/ped_pkg.sv -----
// Shared constants and types for the priority event dispatcher.
package ped_pkg;

    localparam int TASK_ID_W    = 3;
    localparam int SIG_W        = 8;
    localparam int PARAM_W      = 16;
    localparam int PRIO_W       = 4;
    localparam int MASK_W       = 8;
    localparam int AGE_W        = 8;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int PACKED_TASKS = 8;
    localparam int PRIO_LEVELS  = 16;

    localparam logic [AGE_W-1:0]  AGE_MAX  = {AGE_W{1'b1}};
    localparam logic [PRIO_W-1:0] PRIO_TOP = PRIO_W'(PRIO_LEVELS - 1);

    typedef enum logic
    {
        CMD_POST     = 1'b0,
        CMD_DISPATCH = 1'b1
    } command_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        CFG_TASK_COUNT       = 3'd0,
        CFG_TASK_PRIORITIES  = 3'd1,
        CFG_SIGNAL_MASKS     = 3'd2,
        CFG_INTERRUPT_LEVEL  = 3'd3,
        CFG_BROADCAST_ENABLE = 3'd4
    } cfg_index_t;

    typedef struct packed
    {
        logic [SIG_W-1:0]   sig;
        logic [PARAM_W-1:0] param;
    } event_t;

endpackage

// ----- src/ped_in_if.sv -----
// Command channel: valid/ready handshake carrying one post or dispatch item.
interface ped_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [ped_pkg::TASK_ID_W-1:0] target_task;
    logic                          broadcast;
    logic [ped_pkg::SIG_W-1:0]     event_signal;
    logic [ped_pkg::PARAM_W-1:0]   event_param;
    logic [ped_pkg::PRIO_W-1:0]    current_priority;

    modport source
    (
        output valid, command, target_task, broadcast, event_signal, event_param,
               current_priority,
        input  ready
    );

    modport sink
    (
        input  valid, command, target_task, broadcast, event_signal, event_param,
               current_priority,
        output ready
    );
endinterface

// ----- src/ped_out_if.sv -----
// Result channel: valid/ready handshake carrying one post or dispatch result item.
interface ped_out_if;
    logic                          valid;
    logic                          ready;
    logic                          post_accepted;
    logic                          dispatched;
    logic [ped_pkg::TASK_ID_W-1:0] dispatch_task;
    logic [ped_pkg::SIG_W-1:0]     dispatch_signal;
    logic [ped_pkg::PARAM_W-1:0]   dispatch_param;
    logic [ped_pkg::PRIO_W-1:0]    dispatch_priority;

    modport source
    (
        output valid, post_accepted, dispatched, dispatch_task, dispatch_signal,
               dispatch_param, dispatch_priority,
        input  ready
    );

    modport sink
    (
        input  valid, post_accepted, dispatched, dispatch_task, dispatch_signal,
               dispatch_param, dispatch_priority,
        output ready
    );
endinterface

// ----- src/priority_event_dispatcher_core.sv -----
// Priority event dispatcher: per-task event queues with priority dispatch.
//
// Channels: in_ch takes command items (post or dispatch), out_ch returns one
// result item per command. Both use valid/ready; an item moves on a rising
// edge with valid and ready high. Registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no command is
// in flight; the block does not enforce it. Items pass from the input register
// through one queue update and priority/age selection into the result register,
// one item per cycle while out_ch does not stall. A post stores into one task's
// queue, or into every existing task whose mask shares a bit with the signal
// when broadcast is on. If the current priority is below the interrupt level, a
// dispatch pops the oldest event of the highest-priority ready task whose
// priority exceeds the current one, oldest-ready first on ties. Reset empties all
// queues, clears readiness ages and loads register defaults (interrupt level 15,
// everything else 0). When out_ch stalls, the result is held and one more item
// is taken into the input register; in_ch.ready drops until the result is taken.
module priority_event_dispatcher_core #(
    parameter int MAX_TASKS   = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ped_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ped_pkg::CFG_DATA_W-1:0]     cfg_data,
    ped_in_if.sink                             in_ch,
    ped_out_if.source                          out_ch
);

    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int NW = 5;
    localparam logic [FW-1:0] FILL_FULL = FW'(QUEUE_DEPTH);
    localparam logic [FW-1:0] FILL_ONE  = FW'(1);
    localparam logic [QW-1:0] PTR_LAST  = QW'(QUEUE_DEPTH - 1);
    localparam logic [NW-1:0] TASK_MAX  = NW'(MAX_TASKS);

    // configuration
    logic [3:0]                       task_count_reg;
    logic [31:0]                      task_prio_reg;
    logic [63:0]                      sig_mask_reg;
    logic [ped_pkg::PRIO_W-1:0]       int_level_reg;
    logic                             bcast_en_reg;

    // input register
    logic                             in_valid_reg;
    logic                             cmd_reg;
    logic [ped_pkg::TASK_ID_W-1:0]    target_reg;
    logic                             bcast_reg;
    logic [ped_pkg::SIG_W-1:0]        sig_reg;
    logic [ped_pkg::PARAM_W-1:0]      param_reg;
    logic [ped_pkg::PRIO_W-1:0]       cur_reg;

    // queues
    ped_pkg::event_t                  queue_reg [MAX_TASKS][QUEUE_DEPTH];
    logic [QW-1:0]                    wr_ptr_reg  [MAX_TASKS];
    logic [QW-1:0]                    wr_ptr_next [MAX_TASKS];
    logic [QW-1:0]                    rd_ptr_reg  [MAX_TASKS];
    logic [QW-1:0]                    rd_ptr_next [MAX_TASKS];
    logic [FW-1:0]                    fill_reg    [MAX_TASKS];
    logic [FW-1:0]                    fill_next   [MAX_TASKS];
    logic [ped_pkg::AGE_W-1:0]        age_reg     [MAX_TASKS];
    logic [ped_pkg::AGE_W-1:0]        age_next    [MAX_TASKS];

    // result register
    logic                             out_valid_reg;
    logic                             post_acc_reg;
    logic                             post_acc_next;
    logic                             disp_reg;
    logic                             disp_next;
    logic [ped_pkg::TASK_ID_W-1:0]    disp_task_reg;
    logic [ped_pkg::TASK_ID_W-1:0]    disp_task_next;
    logic [ped_pkg::SIG_W-1:0]        disp_sig_reg;
    logic [ped_pkg::SIG_W-1:0]        disp_sig_next;
    logic [ped_pkg::PARAM_W-1:0]      disp_param_reg;
    logic [ped_pkg::PARAM_W-1:0]      disp_param_next;
    logic [ped_pkg::PRIO_W-1:0]       disp_prio_reg;
    logic [ped_pkg::PRIO_W-1:0]       disp_prio_next;

    logic                             process;
    logic                             in_take;
    logic [NW-1:0]                    n_tasks;
    logic [ped_pkg::PRIO_W-1:0]       prio_w [MAX_TASKS];
    logic [ped_pkg::MASK_W-1:0]       mask_w [MAX_TASKS];
    logic [MAX_TASKS-1:0]             store_en;
    logic [MAX_TASKS-1:0]             newly;
    ped_pkg::event_t                  new_event;

    assign process   = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_take   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !in_valid_reg || process;

    assign n_tasks = ({1'b0, task_count_reg} > TASK_MAX) ? TASK_MAX : {1'b0, task_count_reg};
    assign new_event.sig   = sig_reg;
    assign new_event.param = param_reg;

    // unpack per-task priority and mask; tasks beyond the packing get zero
    for (genvar g = 0; g < MAX_TASKS; g++)
    begin : g_task_cfg
        if (g < ped_pkg::PACKED_TASKS)
        begin : g_packed
            logic [ped_pkg::PRIO_W-1:0] raw_prio;
            assign raw_prio  = task_prio_reg[g*ped_pkg::PRIO_W +: ped_pkg::PRIO_W];
            assign prio_w[g] = (raw_prio > ped_pkg::PRIO_TOP) ? ped_pkg::PRIO_TOP : raw_prio;
            assign mask_w[g] = sig_mask_reg[g*ped_pkg::MASK_W +: ped_pkg::MASK_W];
        end
        else
        begin : g_unpacked
            assign prio_w[g] = '0;
            assign mask_w[g] = '0;
        end
    end

    always_comb
    begin
        logic                         is_post;
        logic                         use_bcast;
        logic                         exists;
        logic                         match;
        logic                         acc;
        logic                         found;
        logic [TW-1:0]                best;
        logic [ped_pkg::PRIO_W-1:0]   bp;
        logic [ped_pkg::AGE_W-1:0]    best_age;
        logic                         disp_ok;
        logic [CW-1:0]                new_cnt;
        logic [CW-1:0]                newer_cnt;
        logic [ped_pkg::AGE_W:0]      age_sum;
        ped_pkg::event_t              head;

        is_post   = (cmd_reg == ped_pkg::CMD_POST);
        use_bcast = bcast_reg && bcast_en_reg;
        acc       = 1'b0;

        for (int i = 0; i < MAX_TASKS; i++)
        begin
            exists = (NW'(i) < n_tasks);
            if (use_bcast)
                match = exists && ((mask_w[i] & sig_reg) != '0);
            else
                match = exists && (int'(target_reg) == i);
            store_en[i] = is_post && match && (fill_reg[i] != FILL_FULL);
            newly[i]    = store_en[i] && (fill_reg[i] == '0);
            if (match)
                acc = store_en[i];
        end
        new_cnt = CW'($countones(newly));

        // pick highest priority, then oldest ready
        found    = 1'b0;
        best     = '0;
        bp       = '0;
        best_age = '0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if (fill_reg[i] != '0 &&
                (!found || prio_w[i] > bp || (prio_w[i] == bp && age_reg[i] > best_age)))
            begin
                found    = 1'b1;
                best     = TW'(i);
                bp       = prio_w[i];
                best_age = age_reg[i];
            end
        end
        disp_ok = !is_post && (cur_reg < int_level_reg) && found && (bp > cur_reg);
        head    = queue_reg[best][rd_ptr_reg[best]];

        for (int i = 0; i < MAX_TASKS; i++)
        begin
            wr_ptr_next[i] = wr_ptr_reg[i];
            rd_ptr_next[i] = rd_ptr_reg[i];
            fill_next[i]   = fill_reg[i];
            age_next[i]    = age_reg[i];
            newer_cnt      = CW'($countones(newly >> (i + 1)));
            age_sum        = {1'b0, age_reg[i]} + (ped_pkg::AGE_W + 1)'(new_cnt);
            if (store_en[i])
            begin
                wr_ptr_next[i] = (wr_ptr_reg[i] == PTR_LAST) ? '0 : wr_ptr_reg[i] + 1'b1;
                fill_next[i]   = fill_reg[i] + 1'b1;
            end
            if (newly[i])
                age_next[i] = ped_pkg::AGE_W'(newer_cnt);
            else if (fill_reg[i] != '0)
                age_next[i] = age_sum[ped_pkg::AGE_W] ? ped_pkg::AGE_MAX
                                                      : age_sum[ped_pkg::AGE_W-1:0];
            if (disp_ok && best == TW'(i))
            begin
                rd_ptr_next[i] = (rd_ptr_reg[i] == PTR_LAST) ? '0 : rd_ptr_reg[i] + 1'b1;
                fill_next[i]   = fill_reg[i] - 1'b1;
                if (fill_reg[i] == FILL_ONE)
                    age_next[i] = '0;
            end
        end

        post_acc_next   = is_post && acc;
        disp_next       = disp_ok;
        disp_task_next  = disp_ok ? ped_pkg::TASK_ID_W'(best) : '0;
        disp_sig_next   = disp_ok ? head.sig : '0;
        disp_param_next = disp_ok ? head.param : '0;
        disp_prio_next  = disp_ok ? bp : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= '0;
            task_prio_reg  <= '0;
            sig_mask_reg   <= '0;
            int_level_reg  <= '1;
            bcast_en_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ped_pkg::CFG_TASK_COUNT:       task_count_reg <= cfg_data[3:0];
                ped_pkg::CFG_TASK_PRIORITIES:  task_prio_reg  <= cfg_data[31:0];
                ped_pkg::CFG_SIGNAL_MASKS:     sig_mask_reg   <= cfg_data;
                ped_pkg::CFG_INTERRUPT_LEVEL:  int_level_reg  <= cfg_data[ped_pkg::PRIO_W-1:0];
                ped_pkg::CFG_BROADCAST_ENABLE: bcast_en_reg   <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                wr_ptr_reg[i] <= '0;
                rd_ptr_reg[i] <= '0;
                fill_reg[i]   <= '0;
                age_reg[i]    <= '0;
            end
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (process)
                in_valid_reg <= 1'b0;

            if (process)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            if (process)
            begin
                for (int i = 0; i < MAX_TASKS; i++)
                begin
                    wr_ptr_reg[i] <= wr_ptr_next[i];
                    rd_ptr_reg[i] <= rd_ptr_next[i];
                    fill_reg[i]   <= fill_next[i];
                    age_reg[i]    <= age_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg    <= in_ch.command;
            target_reg <= in_ch.target_task;
            bcast_reg  <= in_ch.broadcast;
            sig_reg    <= in_ch.event_signal;
            param_reg  <= in_ch.event_param;
            cur_reg    <= in_ch.current_priority;
        end
        if (process)
        begin
            post_acc_reg   <= post_acc_next;
            disp_reg       <= disp_next;
            disp_task_reg  <= disp_task_next;
            disp_sig_reg   <= disp_sig_next;
            disp_param_reg <= disp_param_next;
            disp_prio_reg  <= disp_prio_next;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                if (store_en[i])
                    queue_reg[i][wr_ptr_reg[i]] <= new_event;
            end
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.post_accepted     = post_acc_reg;
    assign out_ch.dispatched        = disp_reg;
    assign out_ch.dispatch_task     = disp_task_reg;
    assign out_ch.dispatch_signal   = disp_sig_reg;
    assign out_ch.dispatch_param    = disp_param_reg;
    assign out_ch.dispatch_priority = disp_prio_reg;

endmodule

// ----- verif/tb_priority_event_dispatcher_core.sv -----
`timescale 1ns / 100ps
// Testbench for the priority event dispatcher: directed and random commands checked by a scoreboard.
module tb_priority_event_dispatcher_core;

    localparam int N_TASKS       = 8;
    localparam int DEPTH         = 4;
    localparam int IDLE_LIMIT    = 5000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 100;

    typedef struct packed
    {
        ped_pkg::command_t                command;
        logic [ped_pkg::TASK_ID_W-1:0]    target;
        logic                             bcast;
        logic [ped_pkg::SIG_W-1:0]        sig;
        logic [ped_pkg::PARAM_W-1:0]      param;
        logic [ped_pkg::PRIO_W-1:0]       cur;
    } cmd_item_t;

    typedef struct packed
    {
        logic                             post_accepted;
        logic                             dispatched;
        logic [ped_pkg::TASK_ID_W-1:0]    dispatch_task;
        logic [ped_pkg::SIG_W-1:0]        dispatch_signal;
        logic [ped_pkg::PARAM_W-1:0]      dispatch_param;
        logic [ped_pkg::PRIO_W-1:0]       dispatch_priority;
    } result_t;

    class dispatch_scoreboard;
        logic [3:0]                     n_tasks_reg;
        logic [31:0]                    prio_reg;
        logic [ped_pkg::CFG_DATA_W-1:0] mask_reg;
        logic [ped_pkg::PRIO_W-1:0]     irq_level;
        logic                           bcast_en;

        ped_pkg::event_t                store [N_TASKS][DEPTH];
        logic [1:0]                     wr_ptr [N_TASKS];
        logic [1:0]                     rd_ptr [N_TASKS];
        logic [2:0]                     fill [N_TASKS];
        logic [ped_pkg::AGE_W-1:0]      age [N_TASKS];

        result_t               pending_results [$];
        int                    errors;
        int                    posts;
        int                    stored_posts;
        int                    broadcasts;
        int                    dispatches;
        int                    delivered;

        function new();
            n_tasks_reg = '0;
            prio_reg    = '0;
            mask_reg    = '0;
            irq_level   = 4'd15;
            bcast_en    = 1'b0;
            for (int t = 0; t < N_TASKS; t++)
            begin
                wr_ptr[t] = '0;
                rd_ptr[t] = '0;
                fill[t]   = '0;
                age[t]    = '0;
            end
            errors       = 0;
            posts        = 0;
            stored_posts = 0;
            broadcasts   = 0;
            dispatches   = 0;
            delivered    = 0;
        endfunction

        function void set_reg(ped_pkg::cfg_index_t idx, logic [ped_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ped_pkg::CFG_TASK_COUNT:       n_tasks_reg = data[3:0];
                ped_pkg::CFG_TASK_PRIORITIES:  prio_reg    = data[31:0];
                ped_pkg::CFG_SIGNAL_MASKS:     mask_reg    = data;
                ped_pkg::CFG_INTERRUPT_LEVEL:  irq_level   = data[ped_pkg::PRIO_W-1:0];
                ped_pkg::CFG_BROADCAST_ENABLE: bcast_en    = data[0];
                default: ;
            endcase
        endfunction

        function logic [ped_pkg::PRIO_W-1:0] prio_of(int t);
            logic [ped_pkg::PRIO_W-1:0] p;
            p = prio_reg[t*ped_pkg::PRIO_W +: ped_pkg::PRIO_W];
            if (p > ped_pkg::PRIO_TOP)
                p = ped_pkg::PRIO_TOP;
            return p;
        endfunction

        function bit enqueue(int t, logic [ped_pkg::SIG_W-1:0] s,
                             logic [ped_pkg::PARAM_W-1:0] p);
            if (fill[t] >= DEPTH)
                return 1'b0;
            store[t][wr_ptr[t]] = {s, p};
            wr_ptr[t] = wr_ptr[t] + 2'd1;
            if (fill[t] == 0)
            begin
                for (int i = 0; i < N_TASKS; i++)
                    if (i != t && fill[i] != 0 && age[i] != ped_pkg::AGE_MAX)
                        age[i] = age[i] + 1'b1;
                age[t] = '0;
            end
            fill[t] = fill[t] + 3'd1;
            return 1'b1;
        endfunction

        function void note_item(cmd_item_t it);
            result_t                    r;
            int                         n;
            int                         best;
            bit                         found;
            logic [ped_pkg::PRIO_W-1:0] bp;
            logic [ped_pkg::PRIO_W-1:0] p;
            ped_pkg::event_t            e;
            r = '0;
            n = (n_tasks_reg > N_TASKS) ? N_TASKS : int'(n_tasks_reg);
            if (it.command == ped_pkg::CMD_POST)
            begin
                posts++;
                if (it.bcast && bcast_en)
                begin
                    broadcasts++;
                    for (int t = 0; t < n; t++)
                        if ((mask_reg[t*ped_pkg::MASK_W +: ped_pkg::MASK_W] & it.sig) != '0)
                            r.post_accepted = enqueue(t, it.sig, it.param);
                end
                else if (int'(it.target) < n)
                begin
                    r.post_accepted = enqueue(int'(it.target), it.sig, it.param);
                end
                if (r.post_accepted)
                    stored_posts++;
            end
            else
            begin
                dispatches++;
                if (it.cur < irq_level)
                begin
                    found = 1'b0;
                    best  = 0;
                    bp    = '0;
                    for (int t = 0; t < N_TASKS; t++)
                    begin
                        if (fill[t] != 0)
                        begin
                            p = prio_of(t);
                            if (!found || p > bp || (p == bp && age[t] > age[best]))
                            begin
                                found = 1'b1;
                                best  = t;
                                bp    = p;
                            end
                        end
                    end
                    if (found && bp > it.cur)
                    begin
                        e = store[best][rd_ptr[best]];
                        rd_ptr[best] = rd_ptr[best] + 2'd1;
                        fill[best]   = fill[best] - 3'd1;
                        if (fill[best] == 0)
                            age[best] = '0;
                        r.dispatched        = 1'b1;
                        r.dispatch_task     = ped_pkg::TASK_ID_W'(best);
                        r.dispatch_signal   = e.sig;
                        r.dispatch_param    = e.param;
                        r.dispatch_priority = bp;
                        delivered++;
                    end
                end
            end
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [ped_pkg::PARAM_W-1:0] want,
                                    logic [ped_pkg::PARAM_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result item with no command pending");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("post_accepted", want.post_accepted, got.post_accepted);
            compare_field("dispatched", want.dispatched, got.dispatched);
            compare_field("dispatch_task", want.dispatch_task, got.dispatch_task);
            compare_field("dispatch_signal", want.dispatch_signal, got.dispatch_signal);
            compare_field("dispatch_param", want.dispatch_param, got.dispatch_param);
            compare_field("dispatch_priority", want.dispatch_priority,
                          got.dispatch_priority);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [ped_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ped_pkg::CFG_DATA_W-1:0]  cfg_data;

    ped_in_if  in_ch();
    ped_out_if out_ch();

    priority_event_dispatcher_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    dispatch_scoreboard sb = new();
    int ready_pct        = 100;
    int idle_cycles      = 0;
    int settings_applied = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin : result_monitor
        result_t seen;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            seen = {out_ch.post_accepted, out_ch.dispatched, out_ch.dispatch_task,
                    out_ch.dispatch_signal, out_ch.dispatch_param, out_ch.dispatch_priority};
            sb.check_result(seen);
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("priority_event_dispatcher_core regression: fail");
            $finish;
        end
    end

    initial
    begin : receiver
        bit rdy;
        int run;
        rdy = 1'b0;
        run = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (run == 0)
            begin
                rdy = ($urandom_range(0, 99) < ready_pct);
                run = $urandom_range(1, 12);
            end
            else
            begin
                run--;
            end
            out_ch.ready <= rdy;
        end
    end

    function automatic cmd_item_t make_cmd(ped_pkg::command_t c, int target, bit b, int sig,
                                           int param, int cur);
        cmd_item_t it;
        it.command = c;
        it.target  = ped_pkg::TASK_ID_W'(target);
        it.bcast   = b;
        it.sig     = ped_pkg::SIG_W'(sig);
        it.param   = ped_pkg::PARAM_W'(param);
        it.cur     = ped_pkg::PRIO_W'(cur);
        return it;
    endfunction

    function automatic cmd_item_t random_cmd(int post_pct);
        cmd_item_t it;
        it.command = ($urandom_range(0, 99) < post_pct) ? ped_pkg::CMD_POST
                                                       : ped_pkg::CMD_DISPATCH;
        it.target  = ped_pkg::TASK_ID_W'($urandom_range(0, 7));
        it.bcast   = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0:       it.sig = 8'hFF;
            1:       it.sig = 8'h00;
            2:       it.sig = ped_pkg::SIG_W'(1 << $urandom_range(0, 7));
            default: it.sig = ped_pkg::SIG_W'($urandom);
        endcase
        it.param = ped_pkg::PARAM_W'($urandom);
        if ($urandom_range(0, 3) == 0)
            it.cur = ped_pkg::PRIO_W'($urandom_range(0, 15));
        else
            it.cur = ped_pkg::PRIO_W'($urandom_range(0, 5));
        return it;
    endfunction

    task automatic send_cmd(cmd_item_t it);
        in_ch.valid            <= 1'b1;
        in_ch.command          <= it.command;
        in_ch.target_task      <= it.target;
        in_ch.broadcast        <= it.bcast;
        in_ch.event_signal     <= it.sig;
        in_ch.event_param      <= it.param;
        in_ch.current_priority <= it.cur;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sb.note_item(it);
    endtask

    task automatic hold_off(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic apply_settings(logic [ped_pkg::CFG_DATA_W-1:0] count,
                                  logic [ped_pkg::CFG_DATA_W-1:0] prios,
                                  logic [ped_pkg::CFG_DATA_W-1:0] masks,
                                  logic [ped_pkg::CFG_DATA_W-1:0] level,
                                  logic [ped_pkg::CFG_DATA_W-1:0] ben);
        logic [ped_pkg::CFG_DATA_W-1:0] vals [5];
        vals[0] = count;
        vals[1] = prios;
        vals[2] = masks;
        vals[3] = level;
        vals[4] = ben;
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= ped_pkg::CFG_INDEX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_reg(ped_pkg::cfg_index_t'(i), vals[i]);
        end
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic run_phase(int count, int gap_max, int post_pct);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && sent < count)
            begin
                send_cmd(random_cmd(post_pct));
                sent++;
                burst--;
                if (sent == count / 2)
                    drain();
            end
            if (gap_max > 0 && sent < count && $urandom_range(0, 2) != 0)
                hold_off($urandom_range(1, gap_max));
        end
    endtask

    initial
    begin
        logic [ped_pkg::CFG_DATA_W-1:0] tc;
        logic [ped_pkg::CFG_DATA_W-1:0] pr;
        logic [ped_pkg::CFG_DATA_W-1:0] mk;
        logic [ped_pkg::CFG_DATA_W-1:0] lv;
        logic [ped_pkg::CFG_DATA_W-1:0] be;
        int                             gap_max;

        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= '0;
        cfg_data               <= '0;
        in_ch.valid            <= 1'b0;
        in_ch.command          <= ped_pkg::CMD_POST;
        in_ch.target_task      <= '0;
        in_ch.broadcast        <= 1'b0;
        in_ch.event_signal     <= '0;
        in_ch.event_param      <= '0;
        in_ch.current_priority <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset: no tasks exist
        send_cmd(make_cmd(ped_pkg::CMD_POST, 0, 0, 'h5A, 'h1234, 0));
        send_cmd(make_cmd(ped_pkg::CMD_DISPATCH, 0, 0, 0, 0, 0));
        drain();

        apply_settings(8, 'h7654_3210, 'h8040_2010_0804_0201, 15, 1);
        send_cmd(make_cmd(ped_pkg::CMD_POST, 3, 0, 'hFF, 'hFFFF, 0));
        send_cmd(make_cmd(ped_pkg::CMD_POST, 3, 0, 'h00, 'h0000, 0));
        send_cmd(make_cmd(ped_pkg::CMD_POST, 3, 0, 'hA5, 'h5A5A, 0));
        send_cmd(make_cmd(ped_pkg::CMD_POST, 3, 0, 'h01, 'h0001, 0));
        send_cmd(make_cmd(ped_pkg::CMD_POST, 3, 0, 'h02, 'h0002, 0));
        send_cmd(make_cmd(ped_pkg::CMD_POST, 0, 1, 'hFF, 'hBEEF, 0));
        send_cmd(make_cmd(ped_pkg::CMD_POST, 0, 1, 'h08, 'h0808, 0));
        send_cmd(make_cmd(ped_pkg::CMD_POST, 0, 1, 'h00, 'h0F0F, 0));
        send_cmd(make_cmd(ped_pkg::CMD_DISPATCH, 0, 0, 0, 0, 15));
        send_cmd(make_cmd(ped_pkg::CMD_DISPATCH, 0, 0, 0, 0, 7));
        send_cmd(make_cmd(ped_pkg::CMD_DISPATCH, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ped_pkg::CMD_DISPATCH, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ped_pkg::CMD_DISPATCH, 0, 0, 0, 0, 14));
        drain();

        apply_settings(15, 'hFFFF_FFFF, '1, 0, 0);
        send_cmd(make_cmd(ped_pkg::CMD_POST, 7, 1, 'hFF, 'hFFFF, 15));
        send_cmd(make_cmd(ped_pkg::CMD_DISPATCH, 0, 0, 0, 0, 0));
        drain();

        apply_settings(2, 'hFFFF_FFFF, '1, 15, 1);
        send_cmd(make_cmd(ped_pkg::CMD_POST, 5, 0, 'h11, 'h2222, 0));
        repeat (6) send_cmd(make_cmd(ped_pkg::CMD_DISPATCH, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ped_pkg::CMD_POST, 6, 1, 'h80, 'h8080, 0));
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       tc = 8;
                1:       tc = 1;
                2:       tc = 15;
                default: tc = ($urandom_range(0, 1) != 0) ? 8 : $urandom_range(0, 15);
            endcase
            case (ph)
                3:       pr = '0;
                4:       pr = 'hFFFF_FFFF;
                default: pr = $urandom;
            endcase
            case (ph)
                5:       mk = '1;
                6:       mk = '0;
                default: mk = {$urandom, $urandom};
            endcase
            case (ph)
                0:       lv = 15;
                2:       lv = 0;
                default: lv = ($urandom_range(0, 1) != 0) ? 15 : $urandom_range(0, 15);
            endcase
            be      = (ph == 0) ? 1 : $urandom_range(0, 1);
            gap_max = (ph == 0) ? 0 : $urandom_range(1, 8);
            case ((ph == 0) ? 0 : $urandom_range(0, 2))
                0:       ready_pct <= 100;
                1:       ready_pct <= 75;
                default: ready_pct <= 40;
            endcase
            apply_settings(tc, pr, mk, lv, be);
            run_phase(PHASE_ITEMS, gap_max, $urandom_range(35, 65));
            drain();
        end

        $display("run covered %0d posts (%0d stored, %0d broadcast), %0d dispatches",
                 sb.posts, sb.stored_posts, sb.broadcasts, sb.dispatches);
        $display("with %0d events delivered across %0d register settings",
                 sb.delivered, settings_applied);
        if (sb.errors == 0)
            $display("priority_event_dispatcher_core regression: pass");
        else
            $display("priority_event_dispatcher_core regression: fail");
        $finish;
    end

endmodule
